### rtl/fspa_pkg.sv
// Shared types and constants for the FIFO slot pool allocator.
package fspa_pkg;

	localparam int NUM_SLOTS_DEF   = 4;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	localparam int             CFG_W     = 3;
	localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

	typedef enum logic [1:0] {
		FUNC_REQUEST = 2'd0,
		FUNC_CANCEL  = 2'd1,
		FUNC_DEATH   = 2'd2,
		FUNC_UNUSED  = 2'd3
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_GRANT
	} state_t;

	typedef struct packed {
		logic occupied;
		logic wr;
		logic shift;
	} qcell_ctrl_t;

	typedef struct packed {
		logic en;
		logic free_chk;
		logic grant;
	} scell_ctrl_t;

endpackage

### rtl/fspa_queue_cell.sv
// One entry of the waiting queue: holds an id, compares it, takes its neighbour's id on a shift.
module fspa_queue_cell #(
	parameter int ID_BITS = fspa_pkg::ID_BITS_DEF
) (
	input  logic                  clk,
	input  fspa_pkg::qcell_ctrl_t ctrl,
	input  logic [ID_BITS-1:0]    wr_id,
	input  logic [ID_BITS-1:0]    next_id,
	input  logic [ID_BITS-1:0]    cmp_id,
	output logic [ID_BITS-1:0]    id,
	output logic                  match
);

	logic [ID_BITS-1:0] id_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			id_q <= wr_id;
		end else if (ctrl.shift) begin
			id_q <= next_id;
		end
	end

	assign id    = id_q;
	assign match = ctrl.occupied && (id_q == cmp_id);

endmodule

### rtl/fspa_slot_cell.sv
// One decoder slot: busy flag and owner id, freed on an owner match, loaded on a grant.
module fspa_slot_cell #(
	parameter int ID_BITS = fspa_pkg::ID_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fspa_pkg::scell_ctrl_t ctrl,
	input  logic [ID_BITS-1:0]    cmp_id,
	input  logic [ID_BITS-1:0]    grant_id,
	output logic                  avail
);

	logic               busy_q;
	logic [ID_BITS-1:0] owner_q;
	logic               free_hit;

	assign free_hit = ctrl.free_chk && ctrl.en && busy_q && (owner_q == cmp_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctrl.grant) begin
			busy_q <= 1'b1;
		end else if (free_hit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.grant) begin
			owner_q <= grant_id;
		end
	end

	assign avail = ctrl.en && !busy_q;

endmodule

### rtl/fifo_slot_pool_allocator.sv
// Top level of the FIFO slot pool allocator: queue cell row, slot cell row and sequencing.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | func, client_id, wants_video_decoder
//  out     | output    | out_valid/out_stall | granted, granted_client, granted_slot,
//          |           |                     | request_dropped, waiting_count
//  cfg     | input     | cfg_we              | cfg_wdata (slots_in_use)
//
// Per item, the transfer in ST_IDLE applies the append or removal across the queue
// cell row, then ST_GRANT makes the grant attempt over the slot cells and loads the
// output register. The grant state waits while a held result is stalled.
// Reset is asynchronous; slots come out free, the queue empty, slots_in_use at four.
module fifo_slot_pool_allocator #(
	parameter int NUM_SLOTS   = fspa_pkg::NUM_SLOTS_DEF,
	parameter int QUEUE_DEPTH = fspa_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = fspa_pkg::ID_BITS_DEF,
	localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fspa_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [ID_BITS-1:0]         client_id,
	input  logic                       wants_video_decoder,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       granted,
	output logic [ID_BITS-1:0]         granted_client,
	output logic [SLOT_W-1:0]          granted_slot,
	output logic                       request_dropped,
	output logic [CNT_W-1:0]           waiting_count
);

	logic [fspa_pkg::CFG_W-1:0] cfg_q;
	fspa_pkg::state_t           state_q, state_d;
	logic [CNT_W-1:0]           count_q;
	logic                       attempt_q;
	logic                       dropped_q;

	logic                       out_valid_q;
	logic                       granted_q;
	logic [ID_BITS-1:0]         granted_client_q;
	logic [SLOT_W-1:0]          granted_slot_q;
	logic                       request_dropped_q;
	logic [CNT_W-1:0]           waiting_count_q;

	logic in_xfer;
	logic is_append;
	logic is_remove;
	logic append_ok;
	logic do_attempt;
	logic grant_step;
	logic do_grant;
	logic any_match;
	logic found;
	logic [SLOT_W-1:0] pick;

	logic [QUEUE_DEPTH-1:0] match;
	logic [QUEUE_DEPTH-1:0] prefix;
	logic [ID_BITS-1:0]     qid [QUEUE_DEPTH];
	logic [NUM_SLOTS-1:0]   avail;

	fspa_pkg::func_t func_op;

	assign func_op    = fspa_pkg::func_t'(func);
	assign in_stall   = (state_q != fspa_pkg::ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign is_append  = (func_op == fspa_pkg::FUNC_REQUEST) && wants_video_decoder;
	assign is_remove  = (func_op == fspa_pkg::FUNC_CANCEL) || (func_op == fspa_pkg::FUNC_DEATH);
	assign append_ok  = (count_q < CNT_W'(QUEUE_DEPTH));
	assign do_attempt = is_append || (func_op == fspa_pkg::FUNC_CANCEL);
	assign any_match  = prefix[QUEUE_DEPTH-1];

	assign grant_step = (state_q == fspa_pkg::ST_GRANT) && (!out_valid_q || !out_stall);
	assign do_grant   = grant_step && attempt_q && (count_q != '0) && found;

	// queue cell row
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_q
		fspa_pkg::qcell_ctrl_t qc;
		logic [ID_BITS-1:0]    nxt;

		assign prefix[i] = |match[i:0];

		always_comb begin
			qc.occupied = (CNT_W'(i) < count_q);
			qc.wr       = in_xfer && is_append && append_ok && (count_q == CNT_W'(i));
			qc.shift    = (in_xfer && is_remove && prefix[i]) || do_grant;
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = qid[i+1];
		end

		fspa_queue_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk    (clk),
			.ctrl   (qc),
			.wr_id  (client_id),
			.next_id(nxt),
			.cmp_id (client_id),
			.id     (qid[i]),
			.match  (match[i])
		);
	end

	// slot cell row
	for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_s
		fspa_pkg::scell_ctrl_t sc;

		always_comb begin
			sc.en       = (j < int'(cfg_q));
			sc.free_chk = in_xfer && is_remove;
			sc.grant    = do_grant && (pick == SLOT_W'(j));
		end

		fspa_slot_cell #(
			.ID_BITS(ID_BITS)
		) u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (sc),
			.cmp_id  (client_id),
			.grant_id(qid[0]),
			.avail   (avail[j])
		);
	end

	// highest-index free slot
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			if (avail[j]) begin
				found = 1'b1;
				pick  = SLOT_W'(j);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fspa_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = fspa_pkg::ST_GRANT;
				end
			end
			fspa_pkg::ST_GRANT: begin
				if (grant_step) begin
					state_d = fspa_pkg::ST_IDLE;
				end
			end
			default: state_d = fspa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fspa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fspa_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_xfer) begin
			if (is_append && append_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (is_remove && any_match) begin
				count_q <= count_q - CNT_W'(1);
			end
		end else if (do_grant) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			attempt_q <= do_attempt;
			dropped_q <= is_append && !append_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (grant_step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grant_step) begin
			granted_q         <= do_grant;
			granted_client_q  <= do_grant ? qid[0] : '0;
			granted_slot_q    <= do_grant ? pick : '0;
			request_dropped_q <= dropped_q;
			waiting_count_q   <= do_grant ? (count_q - CNT_W'(1)) : count_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted         = granted_q;
	assign granted_client  = granted_client_q;
	assign granted_slot    = granted_slot_q;
	assign request_dropped = request_dropped_q;
	assign waiting_count   = waiting_count_q;

endmodule

### tb/fspa_checker.sv
// Checker for the FIFO slot pool allocator: tracks all channels, predicts each grant and compares.
module fspa_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fspa_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [7:0]                 client_id,
	input  logic                       wants_video_decoder,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       granted,
	input  logic [7:0]                 granted_client,
	input  logic [1:0]                 granted_slot,
	input  logic                       request_dropped,
	input  logic [4:0]                 waiting_count,
	output int                         fail_count,
	output int                         open_results
);

	typedef struct packed {
		logic       granted;
		logic [7:0] client;
		logic [1:0] slot;
		logic       dropped;
		logic [4:0] waiting;
	} grant_outcome_t;

	logic [fspa_pkg::CFG_W-1:0] slots_cfg;
	logic [7:0]                 waiters[$];
	logic [7:0]                 slot_owner[fspa_pkg::NUM_SLOTS_DEF];
	logic                       slot_busy[fspa_pkg::NUM_SLOTS_DEF];
	grant_outcome_t             pending_outcomes[$];

	function automatic int usable_count();
		return (slots_cfg > fspa_pkg::NUM_SLOTS_DEF) ? fspa_pkg::NUM_SLOTS_DEF : int'(slots_cfg);
	endfunction

	// cancel and death: first queued copy leaves, every slot held in range is freed
	function automatic void release_client(logic [7:0] id);
		int lim;
		lim = usable_count();
		for (int i = 0; i < waiters.size(); i++) begin
			if (waiters[i] == id) begin
				waiters.delete(i);
				break;
			end
		end
		for (int i = 0; i < lim; i++)
			if (slot_busy[i] && slot_owner[i] == id)
				slot_busy[i] = 1'b0;
	endfunction

	function automatic grant_outcome_t allocate_step(fspa_pkg::func_t f, logic [7:0] id,
		logic w);
		grant_outcome_t r;
		logic attempt;
		int lim;
		int pick;
		r = '0;
		attempt = 1'b0;
		case (f)
			fspa_pkg::FUNC_REQUEST: begin
				if (w) begin
					if (waiters.size() < fspa_pkg::QUEUE_DEPTH_DEF)
						waiters = {waiters, id};
					else
						r.dropped = 1'b1;
					attempt = 1'b1;
				end
			end
			fspa_pkg::FUNC_CANCEL: begin
				release_client(id);
				attempt = 1'b1;
			end
			fspa_pkg::FUNC_DEATH: release_client(id);
			default: ;
		endcase
		if (attempt && waiters.size() != 0) begin
			lim = usable_count();
			pick = -1;
			for (int i = 0; i < lim; i++)
				if (!slot_busy[i])
					pick = i;
			if (pick >= 0) begin
				slot_owner[pick] = waiters[0];
				slot_busy[pick] = 1'b1;
				r.granted = 1'b1;
				r.client = waiters.pop_front();
				r.slot = 2'(pick);
			end
		end
		r.waiting = 5'(waiters.size());
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_outcome_t want;
		if (!arst_n) begin
			slots_cfg = fspa_pkg::CFG_RESET;
			waiters.delete();
			pending_outcomes.delete();
			for (int i = 0; i < fspa_pkg::NUM_SLOTS_DEF; i++) begin
				slot_busy[i] = 1'b0;
				slot_owner[i] = '0;
			end
			fail_count = 0;
			open_results = 0;
		end else begin
			// results first, so an output can never match its own input's prediction
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					$error("result transfer with no outcome pending");
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					check_field("granted", 8'(want.granted), 8'(granted));
					check_field("granted_client", want.client, granted_client);
					check_field("granted_slot", 8'(want.slot), 8'(granted_slot));
					check_field("request_dropped", 8'(want.dropped), 8'(request_dropped));
					check_field("waiting_count", 8'(want.waiting), 8'(waiting_count));
				end
			end
			if (cfg_we)
				slots_cfg = cfg_wdata;
			if (in_valid && !in_stall) begin
				want = allocate_step(fspa_pkg::func_t'(func), client_id, wants_video_decoder);
				pending_outcomes = {pending_outcomes, want};
			end
			open_results = pending_outcomes.size();
		end
	end

endmodule

### tb/tb_fifo_slot_pool_allocator.sv
// Testbench top for the FIFO slot pool allocator: clock, reset, stimulus, receiver and verdict.
module tb_fifo_slot_pool_allocator;

	localparam int ITEM_TARGET = 1925;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_AFTER  = 700;
	localparam int HOLD_CYCLES = 400;
	localparam int CFG_BITS    = fspa_pkg::CFG_W;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = fspa_pkg::CFG_RESET;
	logic                in_valid = 1'b0;
	logic                in_stall;
	fspa_pkg::func_t     func = fspa_pkg::FUNC_REQUEST;
	logic [7:0]          client_id = '0;
	logic                wants_video_decoder = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                granted;
	logic [7:0]          granted_client;
	logic [1:0]          granted_slot;
	logic                request_dropped;
	logic [4:0]          waiting_count;
	int                  fail_count;
	int                  open_results;

	int                  items_sent = 0;
	int                  cycle_count = 0;
	bit                  hold_done = 1'b0;
	logic [7:0]          id_pool[8];

	fifo_slot_pool_allocator DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.func                (func),
		.client_id           (client_id),
		.wants_video_decoder (wants_video_decoder),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.granted             (granted),
		.granted_client      (granted_client),
		.granted_slot        (granted_slot),
		.request_dropped     (request_dropped),
		.waiting_count       (waiting_count)
	);

	fspa_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.func                (func),
		.client_id           (client_id),
		.wants_video_decoder (wants_video_decoder),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.granted             (granted),
		.granted_client      (granted_client),
		.granted_slot        (granted_slot),
		.request_dropped     (request_dropped),
		.waiting_count       (waiting_count),
		.fail_count          (fail_count),
		.open_results        (open_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int pick_gap(bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called just after a rising edge; returns just after the edge of the transfer
	task automatic send_item(fspa_pkg::func_t f, logic [7:0] id, logic w, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		client_id <= id;
		wants_video_decoder <= w;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	// register is only written once every outstanding result has been taken
	task automatic drain_and_set_slots(logic [CFG_BITS-1:0] v);
		in_valid <= 1'b0;
		@(negedge clk);
		while (open_results != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: short random stalls, free-flowing stretches, one long hold-off
	initial begin
		int r;
		int n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && items_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				n = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(6, 30);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		int r;
		int n;
		int phase;
		bit no_idle;
		fspa_pkg::func_t f;
		logic [7:0] id;
		logic w;
		logic [CFG_BITS-1:0] v;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no slots: fill the queue to the brim, then overflow it
		drain_and_set_slots(3'd0);
		for (int i = 0; i < fspa_pkg::QUEUE_DEPTH_DEF; i++)
			send_item(fspa_pkg::FUNC_REQUEST, 8'(i * 17), 1'b1, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_REQUEST, 8'hAA, 1'b1, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_REQUEST, 8'h5A, 1'b0, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_UNUSED, 8'h55, 1'b1, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_CANCEL, 8'd17, 1'b0, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_DEATH, 8'h99, 1'b1, pick_gap(1'b0));

		// count above the pool size acts as the full pool
		drain_and_set_slots(3'd7);
		send_item(fspa_pkg::FUNC_CANCEL, 8'h42, 1'b0, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_REQUEST, 8'h33, 1'b1, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_DEATH, 8'd0, 1'b0, pick_gap(1'b0));

		// lowered count: busy slot above it is neither freed nor granted
		drain_and_set_slots(3'd1);
		send_item(fspa_pkg::FUNC_CANCEL, 8'd34, 1'b1, pick_gap(1'b0));
		send_item(fspa_pkg::FUNC_CANCEL, 8'd255, 1'b0, pick_gap(1'b0));

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: v = 3'd4;
				1: v = 3'd2;
				2: v = 3'd0;
				3: v = 3'd7;
				4: v = 3'd3;
				5: v = 3'd5;
				6: v = 3'd6;
				default: v = CFG_BITS'($urandom_range(0, 7));
			endcase
			phase++;
			drain_and_set_slots(v);
			for (int k = 0; k < 8; k++)
				id_pool[k] = 8'($urandom_range(0, 255));
			no_idle = ($urandom_range(0, 3) == 0);
			n = $urandom_range(40, 120);
			repeat (n) begin
				r = $urandom_range(0, 99);
				f = (r < 52) ? fspa_pkg::FUNC_REQUEST : (r < 75) ? fspa_pkg::FUNC_CANCEL :
					(r < 96) ? fspa_pkg::FUNC_DEATH : fspa_pkg::FUNC_UNUSED;
				w = (f == fspa_pkg::FUNC_REQUEST) ? ($urandom_range(0, 9) != 0) :
					1'($urandom_range(0, 1));
				id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 7)] :
					8'($urandom_range(0, 255));
				send_item(f, id, w, pick_gap(no_idle));
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (open_results != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && open_results == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
